>>> src/fpfa_pkg.sv
// shared types and codes for the fixed partition fit allocator
package fpfa_pkg;

  localparam int MODE_BITS      = 2;
  localparam int USE_BITS       = 4;
  localparam int INDEX_BITS     = 3;
  localparam int AMOUNT_BITS    = 16;
  localparam int STATUS_BITS    = 2;
  localparam int CFG_INDEX_BITS = 1;

  // input operations
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // fit modes (the unused code behaves as first fit)
  localparam logic [MODE_BITS-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_WORST = 2'd2;

  // result status codes
  localparam logic [STATUS_BITS-1:0] STATUS_ALLOC    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EXT_FRAG = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_NO_ALLOC = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIT_MODE      = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCKS_IN_USE = 1'd1;

  localparam logic [USE_BITS-1:0] USE_RESET = 4'd8;

  typedef struct packed {
    logic                  op;
    logic [INDEX_BITS-1:0] block_index;
    logic [AMOUNT_BITS-1:0] amount;
  } in_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [INDEX_BITS-1:0]  block_number;
    logic [AMOUNT_BITS-1:0] leftover;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } fsm_state_t;

endpackage

>>> src/fpfa_ram.sv
// generic simple dual port ram with registered read
module fpfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/fixed_partition_fit_allocator_unit.sv
// Fixed partition fit allocator: keeps each block's free size and serves
// first, best and worst fit requests.
//
// Channels: in (valid/ready, in_t) takes loads and requests; out
// (valid/ready, out_t) returns one item per request, none per load; cfg
// (valid/ready, always ready) writes fit_mode (index 0) and blocks_in_use
// (index 1); cfg is to be written only while the block is idle, which the
// block itself does not enforce. A load is written in the cycle it is taken
// and the block stays ready. A request walks the n participating blocks
// through the single read port of the free size ram, one block per cycle
// with one compare/add unit, then moves to write-back (S_FINISH), which
// writes the chosen block's new free size and loads the result register;
// after that the block returns to idle. No new item is taken meanwhile.
// The result sits in an output register; a new item is taken while it
// waits, but a finished request holds in write-back until the register
// frees, so a stalled receiver stalls the block after one more request.
// Reset (rst, synchronous) empties the output register, returns the
// sequencer to idle, clears every block's valid bit so all free sizes
// read as zero, and sets fit_mode to first fit and blocks_in_use to 8.
module fixed_partition_fit_allocator_unit
  import fpfa_pkg::*;
#(
  parameter int NUM_BLOCKS = 8,
  parameter int SIZE_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_t                       in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_t                      out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [USE_BITS-1:0]       cfg_data
);

  localparam int AW       = $clog2(NUM_BLOCKS);
  localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);
  localparam int SUM_BITS = SIZE_BITS + USE_BITS;
  localparam int CW       = (SIZE_BITS > AMOUNT_BITS) ? SIZE_BITS : AMOUNT_BITS;
  localparam int TW       = (SUM_BITS > AMOUNT_BITS) ? SUM_BITS : AMOUNT_BITS;

  fsm_state_t state, state_next;

  logic [MODE_BITS-1:0]   fit_mode;
  logic [USE_BITS-1:0]    blocks_in_use;
  logic [CNT_BITS-1:0]    active_n;

  logic [NUM_BLOCKS-1:0]  entry_valid;
  logic [AMOUNT_BITS-1:0] req_amount;
  logic [CNT_BITS-1:0]    rd_cnt;
  logic                   cmp_vld;
  logic [AW-1:0]          cmp_idx;
  logic                   found;
  logic [AW-1:0]          pick;
  logic [SIZE_BITS-1:0]   pick_free;
  logic [SUM_BITS-1:0]    sum;

  logic                   in_fire;
  logic                   load_fire;
  logic                   issue;
  logic                   out_space;
  logic                   out_load;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [SIZE_BITS-1:0]   wr_data;
  logic [AW-1:0]          rd_addr;
  logic [SIZE_BITS-1:0]   rd_data;
  logic [SIZE_BITS-1:0]   f;
  logic                   fits;
  logic                   take;
  logic [CW-1:0]          diff;
  out_t                   res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= MODE_FIRST;
      blocks_in_use <= USE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIT_MODE:      fit_mode      <= cfg_data[MODE_BITS-1:0];
        CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // counts above the number of blocks saturate
  assign active_n = (int'(blocks_in_use) > NUM_BLOCKS) ? CNT_BITS'(NUM_BLOCKS)
                                                       : CNT_BITS'(blocks_in_use);

  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (in_data.op == OP_LOAD) &&
                     (int'(in_data.block_index) < NUM_BLOCKS);
  assign issue     = (state == S_SCAN) && (rd_cnt < active_n);
  assign rd_addr   = AW'(rd_cnt);
  assign out_space = !out_valid || out_ready;

  // shared compare/accumulate unit
  assign f    = entry_valid[cmp_idx] ? rd_data : '0;
  assign fits = CW'(f) >= CW'(req_amount);
  assign take = fits && (!found ||
                ((fit_mode == MODE_BEST) && (f < pick_free)) ||
                ((fit_mode == MODE_WORST) && (f > pick_free)));
  assign diff = CW'(pick_free) - CW'(req_amount);

  fpfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_free_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && (in_data.op == OP_REQUEST)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue && !cmp_vld) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_space) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = AW'(in_data.block_index);
    wr_data  = SIZE_BITS'(in_data.amount);
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        wr_en    = load_fire;
      end
      S_SCAN: ;
      S_FINISH: begin
        // write-back repeats harmlessly while the output is stalled
        wr_en    = found;
        wr_addr  = pick;
        wr_data  = SIZE_BITS'(diff);
        out_load = out_space;
      end
      default: ;
    endcase
  end

  always_comb begin
    res = '0;
    if (found) begin
      res.status       = STATUS_ALLOC;
      res.block_number = INDEX_BITS'(pick);
      res.leftover     = AMOUNT_BITS'(diff);
    end else if (TW'(req_amount) <= TW'(sum)) begin
      res.status = STATUS_EXT_FRAG;
    end else begin
      res.status = STATUS_NO_ALLOC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
      found   <= 1'b0;
      rd_cnt  <= '0;
    end else begin
      cmp_vld <= issue;
      if (in_fire) begin
        found  <= 1'b0;
        rd_cnt <= '0;
      end else begin
        if (issue) begin
          rd_cnt <= rd_cnt + 1'b1;
        end
        if (cmp_vld && take) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_addr;
    if (in_fire) begin
      req_amount <= in_data.amount;
      sum        <= '0;
    end else if (cmp_vld) begin
      // total of free space at request time, used when refused
      sum <= sum + SUM_BITS'(f);
      if (take) begin
        pick      <= cmp_idx;
        pick_free <= f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  a_idle_no_compare: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !cmp_vld)
    else $error("compare pending while idle");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result loaded outside write-back");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status != STATUS_ALLOC)) |->
      ((out_data.block_number == '0) && (out_data.leftover == '0)))
    else $error("refused item carries a block or leftover");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && found) |-> (CNT_BITS'(pick) < active_n))
    else $error("granted block outside participating range");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (rd_cnt <= active_n))
    else $error("scan address ran past block count");

endmodule

>>> tb/sv/fixed_partition_fit_allocator_unit_test.sv
// testbench for the fixed partition fit allocator: directed and random loads and requests
`timescale 1ns / 100ps

module fixed_partition_fit_allocator_unit_test;
  import fpfa_pkg::*;

  localparam int NUM_BLOCKS    = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 1600;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [USE_BITS-1:0] cfg_data;

  // predicted block state and registers
  logic [AMOUNT_BITS-1:0] free_size [NUM_BLOCKS];
  logic [18:0] free_total;
  logic [MODE_BITS-1:0] fit_mode_q;
  logic [USE_BITS-1:0] blocks_q;

  out_t expected_replies [$];
  int unsigned mismatches = 0;
  bit send_gaps = 1'b1;
  bit take_gaps = 1'b1;
  int unsigned stall_left = 0;

  fixed_partition_fit_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned active_blocks();
    return (blocks_q > NUM_BLOCKS) ? NUM_BLOCKS : blocks_q;
  endfunction

  function automatic void recount_free();
    logic [18:0] sum;
    sum = '0;
    for (int k = 0; k < active_blocks(); k++) sum += free_size[k];
    free_total = sum;
  endfunction

  // applies one accepted item to the predicted state and queues the reply of a request
  function automatic void predict_allocation(in_t item);
    int unsigned n;
    int pick;
    bit found;
    out_t reply;
    n = active_blocks();
    pick = 0;
    found = 1'b0;
    if (item.op == OP_LOAD) begin
      if (item.block_index < NUM_BLOCKS) begin
        free_size[item.block_index] = item.amount;
        recount_free();
      end
      return;
    end
    for (int k = 0; k < n; k++) begin
      if (free_size[k] < item.amount) continue;
      if (!found) begin
        found = 1'b1;
        pick = k;
        if (fit_mode_q != MODE_BEST && fit_mode_q != MODE_WORST) break;
      end else if (fit_mode_q == MODE_BEST && free_size[k] < free_size[pick]) begin
        pick = k;
      end else if (fit_mode_q == MODE_WORST && free_size[k] > free_size[pick]) begin
        pick = k;
      end
    end
    if (found) begin
      free_size[pick] = free_size[pick] - item.amount;
      recount_free();
      reply.status = STATUS_ALLOC;
      reply.block_number = INDEX_BITS'(pick);
      reply.leftover = free_size[pick];
    end else begin
      reply.status = (item.amount <= free_total) ? STATUS_EXT_FRAG : STATUS_NO_ALLOC;
      reply.block_number = '0;
      reply.leftover = '0;
    end
    expected_replies.push_back(reply);
  endfunction

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // entered and left at a falling edge
  task automatic send_item(in_t item);
    int unsigned gap;
    gap = pick_gap(send_gaps);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predict_allocation(item);
    @(negedge clk);
  endtask

  task automatic send_load(logic [INDEX_BITS-1:0] idx, logic [AMOUNT_BITS-1:0] amount);
    in_t item;
    item.op = OP_LOAD;
    item.block_index = idx;
    item.amount = amount;
    send_item(item);
  endtask

  task automatic send_request(logic [AMOUNT_BITS-1:0] amount);
    in_t item;
    item.op = OP_REQUEST;
    item.block_index = INDEX_BITS'($urandom_range(0, NUM_BLOCKS - 1));
    item.amount = amount;
    send_item(item);
  endtask

  // loads leave no reply, so give the block time to finish after the last one
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [USE_BITS-1:0] value);
    wait_until_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FIT_MODE) begin
      fit_mode_q = value[MODE_BITS-1:0];
    end else begin
      blocks_q = value;
      recount_free();
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [AMOUNT_BITS-1:0] pick_load_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return AMOUNT_BITS'($urandom);
    if (r < 75) return AMOUNT_BITS'($urandom_range(0, 4095));
    if (r < 80) return '1;
    return free_size[$urandom_range(0, NUM_BLOCKS - 1)];
  endfunction

  function automatic logic [AMOUNT_BITS-1:0] pick_request_amount();
    int unsigned r;
    logic [AMOUNT_BITS-1:0] room;
    r = $urandom_range(0, 99);
    room = free_size[$urandom_range(0, NUM_BLOCKS - 1)];
    if (r < 25) return AMOUNT_BITS'($urandom_range(0, 1023));
    if (r < 50) return room;
    if (r < 60) return room + 1'b1;
    if (r < 70) return room - 1'b1;
    if (r < 80) return AMOUNT_BITS'($urandom);
    if (r < 85) return '0;
    if (r < 90) return '1;
    if (free_total <= 19'd65535) return free_total[AMOUNT_BITS-1:0];
    return AMOUNT_BITS'($urandom);
  endfunction

  task automatic test_after_reset();
    send_request(16'd0);
    send_request(16'd1);
  endtask

  task automatic test_fit_modes();
    send_load(3'd0, 16'd500);
    send_load(3'd1, 16'd120);
    send_load(3'd2, 16'hFFFF);
    send_load(3'd3, 16'd120);
    send_load(3'd4, 16'd0);
    send_load(3'd5, 16'd900);
    send_load(3'd6, 16'd300);
    send_load(3'd7, 16'hFFFF);
    send_request(16'd200);
    write_register(CFG_FIT_MODE, USE_BITS'(MODE_BEST));
    send_request(16'd120);
    write_register(CFG_FIT_MODE, USE_BITS'(MODE_WORST));
    send_request(16'hFFFF);
    // the unused mode acts as first fit
    write_register(CFG_FIT_MODE, 4'd3);
    send_request(16'hFFFF);
    write_register(CFG_FIT_MODE, USE_BITS'(MODE_FIRST));
    send_request(16'd1000);
    send_request(16'hFFFF);
  endtask

  task automatic test_block_count();
    write_register(CFG_BLOCKS_IN_USE, 4'd0);
    send_request(16'd0);
    send_request(16'd5);
    // saturates to all blocks
    write_register(CFG_BLOCKS_IN_USE, 4'd15);
    send_request(16'd900);
    // block 6 loaded while outside the active range
    write_register(CFG_BLOCKS_IN_USE, 4'd2);
    send_load(3'd6, 16'd5000);
    send_request(16'd4000);
    write_register(CFG_BLOCKS_IN_USE, 4'd7);
    send_request(16'd4000);
  endtask

  task automatic test_random_traffic(int unsigned item_goal);
    int unsigned sent;
    int unsigned phase_len;
    int unsigned r;
    logic [USE_BITS-1:0] count;
    in_t item;
    sent = 0;
    while (sent < item_goal) begin
      send_gaps = ($urandom_range(0, 3) != 0);
      take_gaps = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      write_register(CFG_FIT_MODE, (r < 85) ? USE_BITS'($urandom_range(0, 2))
                                            : USE_BITS'($urandom_range(3, 15)));
      r = $urandom_range(0, 99);
      if (r < 20) count = 4'd8;
      else if (r < 35) count = 4'd1;
      else if (r < 85) count = USE_BITS'($urandom_range(2, 7));
      else if (r < 90) count = 4'd0;
      else count = USE_BITS'($urandom_range(9, 15));
      write_register(CFG_BLOCKS_IN_USE, count);
      // refill every block, then a mix that leans on requests
      for (int k = 0; k < NUM_BLOCKS; k++) send_load(INDEX_BITS'(k), pick_load_amount());
      sent += NUM_BLOCKS;
      phase_len = $urandom_range(40, 160);
      repeat (phase_len) begin
        item.block_index = INDEX_BITS'($urandom_range(0, NUM_BLOCKS - 1));
        if ($urandom_range(0, 99) < 20) begin
          item.op = OP_LOAD;
          item.amount = pick_load_amount();
        end else begin
          item.op = OP_REQUEST;
          item.amount = pick_request_amount();
        end
        send_item(item);
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      automatic int unsigned stall = pick_gap(take_gaps);
      out_ready <= (stall == 0);
      stall_left <= (stall > 0) ? stall - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected item status=%0d", out_data.status));
      end else begin
        automatic out_t want = expected_replies.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_data.status, want.status));
        if (out_data.block_number !== want.block_number)
          report_mismatch($sformatf("block_number %0d, expected %0d",
                                    out_data.block_number, want.block_number));
        if (out_data.leftover !== want.leftover)
          report_mismatch($sformatf("leftover %0d, expected %0d",
                                    out_data.leftover, want.leftover));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int k = 0; k < NUM_BLOCKS; k++) free_size[k] = '0;
    free_total = '0;
    fit_mode_q = MODE_FIRST;
    blocks_q = USE_RESET;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_after_reset();
    test_fit_modes();
    test_block_count();
    test_random_traffic(RANDOM_ITEMS);
    wait_until_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
